/* src/dpcw_pkg.sv */
package dpcw_pkg;

  // Result limits and output queue sizing
  localparam int MAX_RESULTS = 8;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int FIFO_DEPTH  = 2 * MAX_RESULTS;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  // Request codes
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_WATCH   = 2'd1;
  localparam logic [1:0] FUNC_UNWATCH = 2'd2;

  // Level code for unknown raw reading / nothing reported yet
  localparam logic [1:0] LEVEL_UNKNOWN = 2'd2;

  // Result kinds
  localparam logic KIND_CHANGE = 1'b0;
  localparam logic KIND_REPLY  = 1'b1;

  // One watch slot as stored in the slot RAM
  typedef struct packed {
    logic        in_use;
    logic [5:0]  pin;
    logic [15:0] settle;
    logic [1:0]  raw;
    logic [1:0]  rep;
    logic [31:0] chg;
  } slot_rec_t;

  // One result transaction
  typedef struct packed {
    logic       event_kind;
    logic [5:0] pin_number;
    logic       level;
    logic       ok;
    logic       last;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic proc;
    logic fin;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rd_last;
    logic room;
  } dp_status_t;

endpackage

/* src/dpcw_req_if.sv */
interface dpcw_req_if #(
  parameter int PINS = 64
);
  logic            valid;
  logic            ready;
  logic [1:0]      func;
  logic [31:0]     now_ms;
  logic [PINS-1:0] pin_levels;
  logic [5:0]      pin;
  logic [15:0]     settle_ms;

  modport source (output valid, func, now_ms, pin_levels, pin, settle_ms, input ready);
  modport sink (input valid, func, now_ms, pin_levels, pin, settle_ms, output ready);
endinterface

/* src/dpcw_rsp_if.sv */
interface dpcw_rsp_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [5:0] pin_number;
  logic       level;
  logic       ok;
  logic       last;

  modport source (output valid, event_kind, pin_number, level, ok, last, input ready);
  modport sink (input valid, event_kind, pin_number, level, ok, last, output ready);
endinterface

/* src/dpcw_ram.sv */
module dpcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* src/dpcw_fifo.sv */
module dpcw_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dpcw_pkg::result_t  push_data,
  input  logic               pop,
  output dpcw_pkg::result_t  head,
  output logic               not_empty,
  output logic               room
);
  localparam int AW = dpcw_pkg::FIFO_AW;

  dpcw_pkg::result_t mem [dpcw_pkg::FIFO_DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       count;
  logic              do_pop;

  assign do_pop    = pop && not_empty;
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];
  // Enough space left for every result one request can produce
  assign room = (count <= (AW+1)'(dpcw_pkg::FIFO_DEPTH - dpcw_pkg::MAX_RESULTS));

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

/* src/dpcw_ctrl.sv */
module dpcw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output dpcw_pkg::dp_cmd_t    cmd,
  input  dpcw_pkg::dp_status_t st
);
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } ctrl_state_t;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        rd_q;

  // Next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.proc   = rd_q;
    unique case (state)
      ST_IDLE: begin
        in_ready = st.room;
        if (in_valid && st.room) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        if (st.rd_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.fin    = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register; slot processing comes in the cycle after each read
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd_q  <= 1'b0;
    end else begin
      state <= state_next;
      rd_q  <= cmd.rd;
    end
  end
endmodule

/* src/dpcw_dp.sv */
module dpcw_dp #(
  parameter int SLOTS = 8,
  parameter int PINS  = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dpcw_pkg::dp_cmd_t    cmd,
  output dpcw_pkg::dp_status_t st,
  input  logic [1:0]           func,
  input  logic [31:0]          now_ms,
  input  logic [PINS-1:0]      pin_levels,
  input  logic [5:0]           pin,
  input  logic [15:0]          settle_ms,
  output dpcw_pkg::result_t    res,
  output logic                 res_valid,
  input  logic                 res_pop
);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RW = $bits(dpcw_pkg::slot_rec_t);

  // Latched request
  logic [1:0]      func_q;
  logic [31:0]     now_q;
  logic [PINS-1:0] levels_q;
  logic [5:0]      pin_q;
  logic [15:0]     settle_q;

  // Walk and lookup state
  logic [SW-1:0]    rd_addr;
  logic [SW-1:0]    proc_addr;
  logic [SLOTS-1:0] vld;
  logic             match_found;
  logic [SW-1:0]    match_idx;
  logic             free_found;
  logic [SW-1:0]    free_idx;

  // Event collection
  logic [dpcw_pkg::RES_CNT_W-1:0] n_cnt;
  logic                           pend_valid;
  dpcw_pkg::result_t              pend;

  // Combinational
  logic [RW-1:0]         ram_rdata;
  logic                  ram_we;
  logic [SW-1:0]         ram_waddr;
  dpcw_pkg::slot_rec_t   ram_wdata;
  dpcw_pkg::slot_rec_t   rec;
  dpcw_pkg::slot_rec_t   upd;
  dpcw_pkg::slot_rec_t   arm;
  logic                  reading;
  logic                  settled;
  logic                  is_tick;
  logic                  fire;
  logic                  watch_ok;
  logic [SW-1:0]         tgt;
  logic                  push;
  dpcw_pkg::result_t     push_data;
  dpcw_pkg::result_t     new_evt;
  logic                  room;

  assign st.rd_last = (rd_addr == SW'(SLOTS - 1));
  assign st.room    = room;
  assign is_tick    = (func_q == dpcw_pkg::FUNC_TICK);

  dpcw_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Slot update for the entry read last cycle
  always_comb begin
    rec = vld[proc_addr] ? dpcw_pkg::slot_rec_t'(ram_rdata) : '0;
    reading = 1'b0;
    for (int i = 0; i < PINS; i++) begin
      if (rec.pin == 6'(i)) begin
        reading = levels_q[i];
      end
    end
    upd = rec;
    if ({1'b0, reading} != rec.raw) begin
      upd.chg = now_q;
      upd.raw = {1'b0, reading};
    end
    settled = ((now_q - upd.chg) > {16'd0, rec.settle});
    fire = cmd.proc && is_tick && rec.in_use && settled &&
           ({1'b0, reading} != rec.rep) &&
           (n_cnt < dpcw_pkg::RES_CNT_W'(dpcw_pkg::MAX_RESULTS));
    if (fire) begin
      upd.rep = {1'b0, reading};
    end
    new_evt.event_kind = dpcw_pkg::KIND_CHANGE;
    new_evt.pin_number = rec.pin;
    new_evt.level      = reading;
    new_evt.ok         = 1'b0;
    new_evt.last       = 1'b0;
  end

  // Freshly armed watch slot
  always_comb begin
    arm.in_use = 1'b1;
    arm.pin    = pin_q;
    arm.settle = settle_q;
    arm.raw    = dpcw_pkg::LEVEL_UNKNOWN;
    arm.rep    = dpcw_pkg::LEVEL_UNKNOWN;
    arm.chg    = '0;
    watch_ok   = match_found || free_found;
    tgt        = match_found ? match_idx : free_idx;
  end

  // RAM write and result push
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = proc_addr;
    ram_wdata = upd;
    push      = 1'b0;
    push_data = pend;
    if (cmd.proc && is_tick && rec.in_use) begin
      ram_we = 1'b1;
    end
    if (fire && pend_valid) begin
      push = 1'b1;
    end
    if (cmd.fin) begin
      unique case (func_q)
        dpcw_pkg::FUNC_TICK: begin
          push           = pend_valid;
          push_data.last = 1'b1;
        end
        dpcw_pkg::FUNC_WATCH: begin
          ram_we               = watch_ok;
          ram_waddr            = tgt;
          ram_wdata            = arm;
          push                 = 1'b1;
          push_data.event_kind = dpcw_pkg::KIND_REPLY;
          push_data.pin_number = pin_q;
          push_data.level      = 1'b0;
          push_data.ok         = watch_ok;
          push_data.last       = 1'b1;
        end
        dpcw_pkg::FUNC_UNWATCH: begin
          push                 = 1'b1;
          push_data.event_kind = dpcw_pkg::KIND_REPLY;
          push_data.pin_number = pin_q;
          push_data.level      = 1'b0;
          push_data.ok         = match_found;
          push_data.last       = 1'b1;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  // Request capture and slot walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q   <= func;
      now_q    <= now_ms;
      levels_q <= pin_levels;
      pin_q    <= pin;
      settle_q <= settle_ms;
    end
    if (cmd.load) begin
      rd_addr <= '0;
    end else if (cmd.rd) begin
      rd_addr <= rd_addr + 1'b1;
    end
    if (cmd.rd) begin
      proc_addr <= rd_addr;
    end
    if (fire) begin
      pend <= new_evt;
    end
    if (cmd.proc && !match_found && (rec.pin == pin_q)) begin
      match_idx <= proc_addr;
    end
    if (cmd.proc && !free_found && !rec.in_use) begin
      free_idx <= proc_addr;
    end
  end

  // Control state: slot valid bits, lookup flags, event count
  always_ff @(posedge clk) begin
    if (rst) begin
      vld         <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      pend_valid  <= 1'b0;
      n_cnt       <= '0;
    end else begin
      if (cmd.load) begin
        match_found <= 1'b0;
        free_found  <= 1'b0;
        pend_valid  <= 1'b0;
        n_cnt       <= '0;
      end else begin
        if (cmd.proc && (rec.pin == pin_q)) begin
          match_found <= 1'b1;
        end
        if (cmd.proc && !rec.in_use) begin
          free_found <= 1'b1;
        end
        if (fire) begin
          pend_valid <= 1'b1;
          n_cnt      <= n_cnt + 1'b1;
        end else if (cmd.fin) begin
          pend_valid <= 1'b0;
        end
      end
      if (cmd.fin && (func_q == dpcw_pkg::FUNC_WATCH) && watch_ok) begin
        vld[tgt] <= 1'b1;
      end
      if (cmd.fin && (func_q == dpcw_pkg::FUNC_UNWATCH) && match_found) begin
        vld[match_idx] <= 1'b0;
      end
    end
  end

  dpcw_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (res_pop),
    .head      (res),
    .not_empty (res_valid),
    .room      (room)
  );
endmodule

/* src/debounced_pin_change_watcher.sv */
// Channel | Dir | Payload                                        | Transaction
// --------+-----+------------------------------------------------+-----------------------
// req     | in  | func, now_ms, pin_levels, pin, settle_ms       | one tick/watch/unwatch
// rsp     | out | event_kind, pin_number, level, ok, last        | one change or reply
//
// Each request is accepted in IDLE, then the slot RAM is read once per slot in READ, the
// last slot is finished in DRAIN, and FINISH writes the watch slot and queues the reply
// or final result. The walk reads one slot per cycle.
// Reset clears all slots (valid bits), the result queue and the controller at once.
// Results wait in a 16-entry queue; a new request is taken only while at most 8 results
// wait, so rsp stalls hold off requests once more than 8 results are queued.
module debounced_pin_change_watcher #(
  parameter int SLOTS = 8,
  parameter int PINS  = 64
) (
  input logic        clk,
  input logic        rst,
  dpcw_req_if.sink   req,
  dpcw_rsp_if.source rsp
);
  dpcw_pkg::dp_cmd_t    cmd;
  dpcw_pkg::dp_status_t st;
  dpcw_pkg::result_t    res;
  logic                 res_valid;
  logic                 in_ready;

  dpcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .st       (st)
  );

  dpcw_dp #(
    .SLOTS (SLOTS),
    .PINS  (PINS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .func        (req.func),
    .now_ms      (req.now_ms),
    .pin_levels  (req.pin_levels),
    .pin         (req.pin),
    .settle_ms   (req.settle_ms),
    .res         (res),
    .res_valid   (res_valid),
    .res_pop     (rsp.ready)
  );

  assign req.ready      = in_ready;
  assign rsp.valid      = res_valid;
  assign rsp.event_kind = res.event_kind;
  assign rsp.pin_number = res.pin_number;
  assign rsp.level      = res.level;
  assign rsp.ok         = res.ok;
  assign rsp.last       = res.last;
endmodule

/* src/dpcw_checker.sv */
module dpcw_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       rsp_event_kind,
  input logic [5:0] rsp_pin_number,
  input logic       rsp_level,
  input logic       rsp_ok,
  input logic       rsp_last
);
  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid &&
      $stable({rsp_event_kind, rsp_pin_number, rsp_level, rsp_ok, rsp_last}))
    else $error("result changed while stalled");

  // One request at a time: no back-to-back acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous one in progress");

  // A reply is a single result, closes its request and carries no level
  a_reply_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_event_kind |-> rsp_last && !rsp_level)
    else $error("malformed reply");

  // A change event never reports success
  a_change_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_event_kind |-> !rsp_ok)
    else $error("change event with ok set");

  // Nothing is pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result pending after reset");
endmodule

bind debounced_pin_change_watcher dpcw_checker u_dpcw_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_event_kind (rsp.event_kind),
  .rsp_pin_number (rsp.pin_number),
  .rsp_level      (rsp.level),
  .rsp_ok         (rsp.ok),
  .rsp_last       (rsp.last)
);
